### src/fragment_reassembly_assert.svh
// Assertion macros shared by the fragment reassembly RTL
`ifndef FRAGMENT_REASSEMBLY_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fr_pkg.sv
// Types and constants of the fragment reassembly block
package fr_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES_DEF = 65536;
  localparam int unsigned SIZE_W                = 16;
  localparam int unsigned BYTE_W                = 8;

  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ORDER     = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_READ_PAST = 3'd4
  } status_t;

  // One input word as seen by the slot controller
  typedef struct packed {
    logic [1:0]        command;
    logic              stream;
    logic [SIZE_W-1:0] msg_total;
    logic [SIZE_W-1:0] frag_start;
    logic [SIZE_W-1:0] frag_len;
    logic [BYTE_W-1:0] data_byte;
    logic [SIZE_W-1:0] read_index;
  } in_word_t;

  // Result of one word, before the stored byte is attached
  typedef struct packed {
    status_t           status;
    logic              slot_ready;
    logic [SIZE_W-1:0] length;
    logic              rd_ok;
  } res_t;

endpackage

### src/fr_in_if.sv
// Input channel of the fragment reassembly block
interface fr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        stream;
  logic [15:0] msg_total;
  logic [15:0] frag_start;
  logic [15:0] frag_len;
  logic [7:0]  data_byte;
  logic [15:0] read_index;

  modport source (output valid, command, stream, msg_total, frag_start, frag_len,
                  data_byte, read_index, input ready);
  modport sink   (input valid, command, stream, msg_total, frag_start, frag_len,
                  data_byte, read_index, output ready);
endinterface

### src/fr_out_if.sv
// Result channel of the fragment reassembly block
interface fr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        slot_ready;
  logic [15:0] assembled_length;
  logic [7:0]  read_data;

  modport source (output valid, status, slot_ready, assembled_length, read_data,
                  input ready);
  modport sink   (input valid, status, slot_ready, assembled_length, read_data,
                  output ready);
endinterface

### src/fr_ram.sv
// Generic single-port RAM with registered read
module fr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, register read data on re; rdata holds otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### src/fr_slot_ctrl.sv
// Per-slot bookkeeping and byte buffer access control
`include "fragment_reassembly_assert.svh"

module fr_slot_ctrl #(
  parameter int unsigned MAX_MESSAGE_BYTES = fr_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  fr_pkg::in_word_t                       word,
  output fr_pkg::res_t                           res,
  output logic                                   ram_we,
  output logic                                   ram_re,
  output logic [$clog2(MAX_MESSAGE_BYTES):0]     ram_addr,
  output logic [fr_pkg::BYTE_W-1:0]              ram_wdata
);
  import fr_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_MESSAGE_BYTES);
  localparam logic [SIZE_W:0] MAXV = (SIZE_W+1)'(MAX_MESSAGE_BYTES);

  logic [SIZE_W-1:0] exp_r  [2];
  logic [SIZE_W-1:0] held_r [2];
  logic              rdy_r  [2];
  logic [SIZE_W-1:0] pend_r [2];

  logic [SIZE_W-1:0] exp_nxt, held_nxt, pend_nxt;
  logic              rdy_nxt;
  logic [SIZE_W-1:0] exp_cur, held_cur, pend_cur;
  logic              rdy_cur;
  logic [SIZE_W:0]   span;
  status_t           status;
  logic              we_c, re_c;
  logic [IW-1:0]     pos;
  logic [SIZE_W:0]   occ0, occ1;
  logic              fit0, fit1;

  assign exp_cur  = exp_r[word.stream];
  assign held_cur = held_r[word.stream];
  assign rdy_cur  = rdy_r[word.stream];
  assign pend_cur = pend_r[word.stream];

  // Decide the new slot state, the status and the buffer access
  always_comb begin
    exp_nxt  = exp_cur;
    held_nxt = held_cur;
    rdy_nxt  = rdy_cur;
    pend_nxt = pend_cur;
    status   = ST_OK;
    we_c     = 1'b0;
    re_c     = 1'b0;
    pos      = held_cur[IW-1:0];
    span     = '0;
    unique case (cmd_t'(word.command))
      CMD_HEADER: begin
        // take a new total, clearing the slot if it differs from the old one
        if (exp_cur == '0) begin
          exp_nxt = word.msg_total;
        end else if (word.msg_total != exp_cur) begin
          exp_nxt  = word.msg_total;
          held_nxt = '0;
          rdy_nxt  = 1'b0;
        end
        pend_nxt = '0;
        span     = {1'b0, held_nxt} + {1'b0, word.frag_len};
        if (word.frag_start != held_nxt) begin
          status = ST_ORDER;
        end else if (span > {1'b0, exp_nxt} || span > MAXV) begin
          status = ST_OVERRUN;
        end else begin
          pend_nxt = word.frag_len;
          if (held_nxt == exp_nxt) begin
            rdy_nxt = 1'b1;
          end
        end
      end
      CMD_DATA: begin
        // append one byte while the fragment still owes bytes
        if (pend_cur == '0 || {1'b0, held_cur} >= MAXV) begin
          status = ST_IGNORED;
        end else begin
          we_c     = 1'b1;
          held_nxt = held_cur + SIZE_W'(1);
          pend_nxt = pend_cur - SIZE_W'(1);
          if (held_nxt == exp_cur) begin
            rdy_nxt = 1'b1;
          end
        end
      end
      CMD_READ: begin
        pos = word.read_index[IW-1:0];
        if (word.read_index >= held_cur || {1'b0, word.read_index} >= MAXV) begin
          status = ST_READ_PAST;
        end else begin
          re_c = 1'b1;
        end
      end
      CMD_RELEASE: begin
        exp_nxt  = '0;
        held_nxt = '0;
        rdy_nxt  = 1'b0;
        pend_nxt = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign res.status     = status;
  assign res.slot_ready = rdy_nxt;
  assign res.length     = held_nxt;
  assign res.rd_ok      = re_c;

  assign ram_we    = accept && we_c;
  assign ram_re    = accept && re_c;
  assign ram_addr  = {word.stream, pos};
  assign ram_wdata = word.data_byte;

  // Write back the addressed slot on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        exp_r[i]  <= '0;
        held_r[i] <= '0;
        rdy_r[i]  <= 1'b0;
        pend_r[i] <= '0;
      end
    end else if (accept) begin
      exp_r[word.stream]  <= exp_nxt;
      held_r[word.stream] <= held_nxt;
      rdy_r[word.stream]  <= rdy_nxt;
      pend_r[word.stream] <= pend_nxt;
    end
  end

  // Bytes held plus bytes still owed must fit the total and the buffer
  assign occ0 = {1'b0, held_r[0]} + {1'b0, pend_r[0]};
  assign occ1 = {1'b0, held_r[1]} + {1'b0, pend_r[1]};
  assign fit0 = (occ0 <= {1'b0, exp_r[0]}) && (occ0 <= MAXV);
  assign fit1 = (occ1 <= {1'b0, exp_r[1]}) && (occ1 <= MAXV);

  `FR_ASSERT_NOW(a_slot0_fits, 1'b1, fit0, "slot 0 owes bytes beyond its total")
  `FR_ASSERT_NOW(a_slot1_fits, 1'b1, fit1, "slot 1 owes bytes beyond its total")
  `FR_ASSERT_NOW(a_one_access, ram_we, !ram_re, "buffer written and read in one cycle")

endmodule

### src/fragment_reassembly.sv
// Fragment reassembly: two in-order reassembly slots over one byte buffer.
// The block takes one word per clock cycle, every kind of word alike, when
// the result side does not stall, and returns one result word for each through
// the buffer stage and then the output register. The rate is set by the
// single-port byte buffer, which sees at most one access per word: a write
// for a data byte or a read for a read word. Slot bookkeeping is read,
// updated and written back in the accepting cycle. The buffer holds
// 2 * 2**clog2(MAX_MESSAGE_BYTES) bytes and needs no clearing after reset,
// since only bytes below a slot's held length are ever read back.
`include "fragment_reassembly_assert.svh"

module fragment_reassembly #(
  parameter int unsigned MAX_MESSAGE_BYTES = fr_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  fr_in_if.sink    in_ch,
  fr_out_if.source out_ch
);
  import fr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_MESSAGE_BYTES) + 1;

  in_word_t          word;
  res_t              res;
  logic              accept, s1_adv;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic              s1_valid_r, s1_valid_nxt;
  res_t              s1_res_r;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic              out_ready_mark_r;
  logic [SIZE_W-1:0] out_length_r;
  logic [BYTE_W-1:0] out_data_r;

  assign word.command    = in_ch.command;
  assign word.stream     = in_ch.stream;
  assign word.msg_total  = in_ch.msg_total;
  assign word.frag_start = in_ch.frag_start;
  assign word.frag_len   = in_ch.frag_len;
  assign word.data_byte  = in_ch.data_byte;
  assign word.read_index = in_ch.read_index;

  // Advance the buffer stage whenever the output register is free or drains
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  fr_slot_ctrl #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .word     (word),
    .res      (res),
    .ram_we   (ram_we),
    .ram_re   (ram_re),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata)
  );

  fr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(2 ** AW)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Next valid flags of the buffer stage and the output register
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result while the buffer read completes, then attach the byte
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
    if (s1_valid_r && s1_adv) begin
      out_status_r     <= s1_res_r.status;
      out_ready_mark_r <= s1_res_r.slot_ready;
      out_length_r     <= s1_res_r.length;
      out_data_r       <= s1_res_r.rd_ok ? ram_rdata : '0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.slot_ready       = out_ready_mark_r;
  assign out_ch.assembled_length = out_length_r;
  assign out_ch.read_data        = out_data_r;

  `FR_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_res_r), "stalled buffer stage lost its word")

endmodule

### dv/tb.sv
// Self-checking testbench for the fragment reassembly block
module tb;
  import fr_pkg::*;

  localparam int unsigned MSG_BYTES = MAX_MESSAGE_BYTES_DEF;
  localparam int unsigned N_DIR     = 25;
  localparam int unsigned N_RAND    = 1925;
  localparam int unsigned N_WORDS   = N_DIR + N_RAND;
  localparam int unsigned QUIET_LO  = 900;
  localparam int unsigned QUIET_HI  = 1200;
  localparam int unsigned STALL_MAX = 2000;
  localparam int unsigned TAIL      = 8;

  // One result word as the checker sees it
  typedef struct packed {
    status_t     status;
    logic        slot_ready;
    logic [15:0] held;
    logic [7:0]  rdata;
  } reply_t;

  typedef struct {
    in_word_t w;
    bit       typed;
    reply_t   r;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fr_in_if  in_bus ();
  fr_out_if out_bus ();

  fragment_reassembly dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #10 clk = ~clk;

  // Slot bookkeeping mirrored from the block's behaviour
  int unsigned want_total [2] = '{0, 0};
  int unsigned have_len   [2] = '{0, 0};
  int unsigned still_due  [2] = '{0, 0};
  bit          done_mark  [2] = '{0, 0};
  logic [7:0]  msg_store  [2][MSG_BYTES];

  reply_t      reply_q [$];
  plan_row_t   plan [N_DIR];

  int unsigned words_in     = 0;
  int unsigned results_seen = 0;
  int unsigned next_row     = 0;
  int unsigned errors       = 0;
  int unsigned completions  = 0;
  int unsigned quiet        = 0;

  // Random sequence generator state
  bit          gen_slot   = 1'b0;
  int unsigned gen_total  = 0;
  int          frag_left  = 0;
  int          reads_left = 0;
  bit          msg_active = 1'b0;

  in_word_t    on_bus;
  bit          on_typed;
  reply_t      on_reply;

  function automatic in_word_t mk(cmd_t c, bit s, int unsigned t, int unsigned o,
                                  int unsigned z, int unsigned b, int unsigned i);
    in_word_t w;
    w.command    = c;
    w.stream     = s;
    w.msg_total  = 16'(t);
    w.frag_start = 16'(o);
    w.frag_len   = 16'(z);
    w.data_byte  = 8'(b);
    w.read_index = 16'(i);
    return w;
  endfunction

  function automatic reply_t ans(status_t st, bit rdy, int unsigned len, int unsigned d);
    reply_t r;
    r.status     = st;
    r.slot_ready = rdy;
    r.held       = 16'(len);
    r.rdata      = 8'(d);
    return r;
  endfunction

  function automatic void drop_slot(int unsigned s);
    want_total[s] = 0;
    have_len[s]   = 0;
    still_due[s]  = 0;
    done_mark[s]  = 1'b0;
  endfunction

  function automatic void mark_done(int unsigned s);
    if (!done_mark[s]) completions++;
    done_mark[s] = 1'b1;
  endfunction

  // Advance the slot state by one word and return the result it should give
  function automatic reply_t apply_word(in_word_t w);
    reply_t      r;
    int unsigned s;
    s = w.stream;
    r = '0;
    r.status = ST_OK;
    case (w.command)
      CMD_HEADER: begin
        if (want_total[s] == 0) begin
          want_total[s] = w.msg_total;
        end else if (w.msg_total != want_total[s]) begin
          drop_slot(s);
          want_total[s] = w.msg_total;
        end
        still_due[s] = 0;
        if (w.frag_start != have_len[s]) begin
          r.status = ST_ORDER;
        end else if (have_len[s] + w.frag_len > want_total[s] ||
                     have_len[s] + w.frag_len > MSG_BYTES) begin
          r.status = ST_OVERRUN;
        end else begin
          still_due[s] = w.frag_len;
          if (have_len[s] == want_total[s]) mark_done(s);
        end
      end
      CMD_DATA: begin
        if (still_due[s] == 0 || have_len[s] >= MSG_BYTES) begin
          r.status = ST_IGNORED;
        end else begin
          msg_store[s][have_len[s]] = w.data_byte;
          have_len[s]++;
          still_due[s]--;
          if (have_len[s] == want_total[s]) mark_done(s);
        end
      end
      CMD_READ: begin
        if (w.read_index >= have_len[s] || w.read_index >= MSG_BYTES) begin
          r.status = ST_READ_PAST;
        end else begin
          r.rdata = msg_store[s][w.read_index];
        end
      end
      default: drop_slot(s);
    endcase
    r.slot_ready = done_mark[s];
    r.held       = 16'(have_len[s]);
    return r;
  endfunction

  function automatic int unsigned pick_total();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 0;
    if (roll < 8) return $urandom_range(49, 600);
    return $urandom_range(1, 48);
  endfunction

  function automatic logic [15:0] pick_index(bit s);
    if ($urandom_range(0, 99) < 12) return 16'($urandom);
    return 16'($urandom_range(0, have_len[s] + 1));
  endfunction

  // Build the next random word: mostly in-order messages, some noise
  function automatic in_word_t next_random_word();
    in_word_t    w;
    int unsigned roll;
    int unsigned start;
    int unsigned room;
    int unsigned due;
    w.command    = 2'($urandom);
    w.stream     = 1'($urandom);
    w.msg_total  = 16'($urandom);
    w.frag_start = 16'($urandom);
    w.frag_len   = 16'($urandom);
    w.data_byte  = 8'($urandom);
    w.read_index = 16'($urandom);
    roll = $urandom_range(0, 99);

    // pass pure noise through untouched
    if (roll < 4) return w;

    // payload of the current fragment, with the odd read on either slot
    if (frag_left > 0) begin
      if (roll < 9) begin
        w.command    = CMD_READ;
        w.read_index = pick_index(w.stream);
      end else begin
        w.command = CMD_DATA;
        w.stream  = gen_slot;
        frag_left--;
      end
      return w;
    end

    // message complete: read some of it back
    if (msg_active && want_total[gen_slot] == gen_total && have_len[gen_slot] == gen_total) begin
      msg_active = 1'b0;
      reads_left = $urandom_range(1, 4);
    end
    if (reads_left > 0) begin
      w.command    = CMD_READ;
      w.stream     = gen_slot;
      w.read_index = pick_index(gen_slot);
      reads_left--;
      return w;
    end

    // open a new message, sometimes releasing the slot first
    if (!msg_active) begin
      gen_slot   = 1'($urandom);
      gen_total  = pick_total();
      msg_active = 1'b1;
      if ($urandom_range(0, 99) < 40) begin
        w.command = CMD_RELEASE;
        w.stream  = gen_slot;
        return w;
      end
    end

    // next fragment header; a different total empties the slot
    start = (want_total[gen_slot] != 0 && want_total[gen_slot] != gen_total) ?
            0 : have_len[gen_slot];
    room  = (gen_total > start) ? gen_total - start : 0;
    due   = (room == 0) ? 0 : $urandom_range(1, (room < 64) ? room : 64);
    w.command    = CMD_HEADER;
    w.stream     = gen_slot;
    w.msg_total  = 16'(gen_total);
    w.frag_start = 16'(start);
    w.frag_len   = 16'(due);
    frag_left    = due;
    if (roll < 12) begin
      w.frag_start = 16'($urandom);
      frag_left    = $urandom_range(0, 2);
    end else if (roll < 18) begin
      w.frag_len = $urandom_range(0, 1) ? 16'(room + $urandom_range(1, 4)) : 16'($urandom);
      frag_left  = $urandom_range(0, 2);
    end else if (roll < 20) begin
      msg_active = 1'b0;
    end
    return w;
  endfunction

  function automatic bit take_break(int unsigned count);
    return (count < QUIET_LO || count >= QUIET_HI) && $urandom_range(0, 99) < 9;
  endfunction

  task automatic put_word(in_word_t w);
    in_bus.command    <= w.command;
    in_bus.stream     <= w.stream;
    in_bus.msg_total  <= w.msg_total;
    in_bus.frag_start <= w.frag_start;
    in_bus.frag_len   <= w.frag_len;
    in_bus.data_byte  <= w.data_byte;
    in_bus.read_index <= w.read_index;
  endtask

  task automatic log_fault(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Drive words, predict on acceptance, check results, watch for stalls
  initial begin : traffic
    reply_t got;
    reply_t want;
    bit     moved;
    in_bus.valid  <= 1'b0;
    out_bus.ready <= 1'b0;
    put_word('0);
    forever begin
      @(posedge clk);
      if (rst_n) begin
        moved = 1'b0;

        // predict the accepted word
        if (in_bus.valid && in_bus.ready) begin
          want = apply_word(on_bus);
          reply_q.push_back(on_typed ? on_reply : want);
          words_in++;
          moved = 1'b1;
        end

        // check the accepted result against the oldest prediction
        if (out_bus.valid && out_bus.ready) begin
          got = {out_bus.status, out_bus.slot_ready, out_bus.assembled_length,
                 out_bus.read_data};
          results_seen++;
          moved = 1'b1;
          if (reply_q.size() == 0) begin
            log_fault($sformatf("unexpected result: status %0d ready %0d len %0d data %0h",
                                got.status, got.slot_ready, got.held, got.rdata));
          end else begin
            want = reply_q[0];
            reply_q.delete(0);
            if (got.status !== want.status || got.slot_ready !== want.slot_ready ||
                got.held !== want.held || got.rdata !== want.rdata) begin
              log_fault($sformatf({"result %0d: expected status %0d ready %0d len %0d ",
                                   "data %0h, got status %0d ready %0d len %0d data %0h"},
                                  results_seen, want.status, want.slot_ready, want.held,
                                  want.rdata, got.status, got.slot_ready, got.held,
                                  got.rdata));
            end
          end
        end

        // present the next word, or hold off
        if (!in_bus.valid || in_bus.ready) begin
          if (next_row == N_WORDS || take_break(words_in)) begin
            in_bus.valid <= 1'b0;
          end else begin
            if (next_row < N_DIR) begin
              on_bus   = plan[next_row].w;
              on_typed = plan[next_row].typed;
              on_reply = plan[next_row].r;
            end else begin
              on_bus   = next_random_word();
              on_typed = 1'b0;
            end
            next_row++;
            put_word(on_bus);
            in_bus.valid <= 1'b1;
          end
        end

        out_bus.ready <= !take_break(results_seen);

        // end the run if nothing moves for too long
        quiet = moved ? 0 : quiet + 1;
        if (quiet == STALL_MAX) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Directed table, reset and end of run
  initial begin
    plan[0]  = '{mk(CMD_READ,    0, 0,       0,       0,       0,    0),
                 1'b1, ans(ST_READ_PAST, 0, 0, 0)};
    plan[1]  = '{mk(CMD_DATA,    1, 0,       0,       0,       8'h77, 0),
                 1'b1, ans(ST_IGNORED, 0, 0, 0)};
    plan[2]  = '{mk(CMD_HEADER,  0, 4,       1,       2,       0,    0),
                 1'b1, ans(ST_ORDER, 0, 0, 0)};
    plan[3]  = '{mk(CMD_HEADER,  0, 4,       0,       5,       0,    0),
                 1'b1, ans(ST_OVERRUN, 0, 0, 0)};
    plan[4]  = '{mk(CMD_HEADER,  0, 4,       0,       2,       0,    0),
                 1'b1, ans(ST_OK, 0, 0, 0)};
    plan[5]  = '{mk(CMD_DATA,    0, 0,       0,       0,       8'hFF, 0), 1'b0, '0};
    plan[6]  = '{mk(CMD_DATA,    0, 0,       0,       0,       8'h00, 0), 1'b0, '0};
    // stray byte once the fragment is used up
    plan[7]  = '{mk(CMD_DATA,    0, 0,       0,       0,       8'h12, 0),
                 1'b1, ans(ST_IGNORED, 0, 2, 0)};
    plan[8]  = '{mk(CMD_HEADER,  0, 4,       2,       2,       0,    0), 1'b0, '0};
    plan[9]  = '{mk(CMD_DATA,    0, 0,       0,       0,       8'hA5, 0), 1'b0, '0};
    // header in mid-fragment drops the rest of the pending count
    plan[10] = '{mk(CMD_HEADER,  0, 4,       3,       1,       0,    0), 1'b0, '0};
    plan[11] = '{mk(CMD_DATA,    0, 0,       0,       0,       8'h5A, 0),
                 1'b1, ans(ST_OK, 1, 4, 0)};
    plan[12] = '{mk(CMD_READ,    0, 0,       0,       0,       0,    0),
                 1'b1, ans(ST_OK, 1, 4, 8'hFF)};
    plan[13] = '{mk(CMD_READ,    0, 0,       0,       0,       0,    3), 1'b0, '0};
    plan[14] = '{mk(CMD_READ,    0, 0,       0,       0,       0,    4),
                 1'b1, ans(ST_READ_PAST, 1, 4, 0)};
    plan[15] = '{mk(CMD_READ,    0, 0,       0,       0,       0,    16'hFFFF),
                 1'b1, ans(ST_READ_PAST, 1, 4, 0)};
    plan[16] = '{mk(CMD_HEADER,  0, 4,       4,       0,       0,    0), 1'b0, '0};
    // zero total marks the slot ready at once, and the mark survives a new total
    plan[17] = '{mk(CMD_HEADER,  1, 0,       0,       0,       0,    0),
                 1'b1, ans(ST_OK, 1, 0, 0)};
    plan[18] = '{mk(CMD_HEADER,  1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0),
                 1'b1, ans(ST_ORDER, 1, 0, 0)};
    plan[19] = '{mk(CMD_HEADER,  1, 16'hFFFF, 0,      16'hFFFF, 0,    0), 1'b0, '0};
    plan[20] = '{mk(CMD_DATA,    1, 0,       0,       0,       8'h3C, 0), 1'b0, '0};
    // a different total empties the slot before the offset check
    plan[21] = '{mk(CMD_HEADER,  1, 16'hFFFE, 1,      0,       0,    0),
                 1'b1, ans(ST_ORDER, 0, 0, 0)};
    plan[22] = '{mk(CMD_RELEASE, 0, 0,       0,       0,       0,    0),
                 1'b1, ans(ST_OK, 0, 0, 0)};
    plan[23] = '{mk(CMD_RELEASE, 1, 0,       0,       0,       0,    0),
                 1'b1, ans(ST_OK, 0, 0, 0)};
    plan[24] = '{mk(CMD_READ,    0, 0,       0,       0,       0,    0),
                 1'b1, ans(ST_READ_PAST, 0, 0, 0)};

    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to be taken and every result to arrive
    wait (words_in == N_WORDS && reply_q.size() == 0);
    repeat (TAIL) @(posedge clk);
    if (reply_q.size() != 0) begin
      log_fault($sformatf("%0d results never arrived", reply_q.size()));
    end

    $display("Sent %0d words (%0d directed) over both slots, checked %0d results",
             words_in, N_DIR, results_seen);
    $display("%0d messages reached the ready mark, %0d mismatches", completions, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
